// ===== hw/rtl/euler_circuit_hierholzer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Euler circuit unit assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef EULER_CIRCUIT_HIERHOLZER_UNIT_DEFINES_SVH
`define EULER_CIRCUIT_HIERHOLZER_UNIT_DEFINES_SVH

// Property that must hold at every edge out of reset
`define ECH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// Trigger in one cycle implies the consequence in the next cycle
`define ECH_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ech_pkg.sv =====
// ----------------------------------------------------------------------------
// ech_pkg
// Types, constants and helper functions of the Euler circuit unit.
// ----------------------------------------------------------------------------
package ech_pkg;

  // Sizes
  localparam int MAX_VERTICES = 64;
  localparam int PATH_DEPTH   = 4096;
  localparam int VTX_W        = 7;
  localparam int IDX_W        = 12;
  localparam int LEN_W        = 13;
  localparam int ACTION_W     = 2;
  localparam int STATUS_W     = 2;
  localparam int ROW_AW       = $clog2(MAX_VERTICES);
  localparam int PATH_AW      = $clog2(PATH_DEPTH);
  localparam int SP_W         = PATH_AW + 1;

  localparam logic [VTX_W-1:0] VC_RESET = VTX_W'(MAX_VERTICES);

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RUN   = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_START = 2'd2;

  // Command word
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [VTX_W-1:0]    row_vertex;
    logic [VTX_W-1:0]    col_vertex;
    logic                edge_present;
    logic [VTX_W-1:0]    start_vertex;
    logic [IDX_W-1:0]    read_index;
  } cmd_word_t;

  // Response word
  typedef struct packed {
    logic [VTX_W-1:0]    vertex;
    logic [LEN_W-1:0]    path_length;
    logic [STATUS_W-1:0] status;
  } rsp_word_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LD_RD_ROW,
    ST_LD_WR_ROW,
    ST_LD_RD_COL,
    ST_LD_WR_COL,
    ST_RUN_INIT,
    ST_RUN_RD,
    ST_RUN_EVAL,
    ST_RUN_FETCH,
    ST_RESP
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take;
    logic clear_rows;
    logic ld_rd_row;
    logic ld_wr_row;
    logic ld_rd_col;
    logic ld_wr_col;
    logic run_init;
    logic run_rd;
    logic run_eval;
    logic run_fetch;
    logic rsp_load;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                load_go;
    logic                start_ok;
    logic                push;
    logic                run_last;
    logic                rsp_free;
  } dp_stat_t;

  // Row address of vertex v (1-based)
  function automatic logic [ROW_AW-1:0] vtx_addr(input logic [VTX_W-1:0] v);
    logic [VTX_W-1:0] t;
    t = v - VTX_W'(1);
    return t[ROW_AW-1:0];
  endfunction

  // One-hot row mask of vertex v (1-based)
  function automatic logic [MAX_VERTICES-1:0] vtx_bit(input logic [VTX_W-1:0] v);
    logic [MAX_VERTICES-1:0] m;
    m = '0;
    m[vtx_addr(v)] = 1'b1;
    return m;
  endfunction

  // Index of the lowest set bit of a row
  function automatic logic [ROW_AW-1:0] lowest_set(input logic [MAX_VERTICES-1:0] r);
    logic [ROW_AW-1:0] idx;
    idx = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (r[i]) idx = ROW_AW'(i);
    end
    return idx;
  endfunction

endpackage

// ===== hw/rtl/ech_ram.sv =====
// ----------------------------------------------------------------------------
// ech_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ech_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/ech_ctrl.sv =====
// ----------------------------------------------------------------------------
// ech_ctrl
// Sequencer of the Euler circuit unit: decodes actions and steps the walk.
// ----------------------------------------------------------------------------
module ech_ctrl
  import ech_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

`include "euler_circuit_hierholzer_unit_defines.svh"

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (cmd_valid) state_next = ST_DECODE;
      ST_DECODE: begin
        unique case (stat.action)
          ACT_CLEAR: state_next = ST_RESP;
          ACT_LOAD:  state_next = stat.load_go ? ST_LD_RD_ROW : ST_RESP;
          ACT_RUN:   state_next = stat.start_ok ? ST_RUN_INIT : ST_RESP;
          ACT_READ:  state_next = ST_RESP;
        endcase
      end
      ST_LD_RD_ROW: state_next = ST_LD_WR_ROW;
      ST_LD_WR_ROW: state_next = ST_LD_RD_COL;
      ST_LD_RD_COL: state_next = ST_LD_WR_COL;
      ST_LD_WR_COL: state_next = ST_RESP;
      ST_RUN_INIT:  state_next = ST_RUN_RD;
      ST_RUN_RD:    state_next = ST_RUN_EVAL;
      ST_RUN_EVAL: begin
        priority if (stat.push)     state_next = ST_RUN_RD;
        else if     (stat.run_last) state_next = ST_RESP;
        else                        state_next = ST_RUN_FETCH;
      end
      ST_RUN_FETCH: state_next = ST_RUN_EVAL;
      ST_RESP:      if (stat.rsp_free) state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd            = '0;
    cmd_stall      = (state != ST_IDLE);
    cmd.take       = (state == ST_IDLE) && cmd_valid;
    cmd.clear_rows = (state == ST_DECODE) && (stat.action == ACT_CLEAR);
    cmd.ld_rd_row  = (state == ST_LD_RD_ROW);
    cmd.ld_wr_row  = (state == ST_LD_WR_ROW);
    cmd.ld_rd_col  = (state == ST_LD_RD_COL);
    cmd.ld_wr_col  = (state == ST_LD_WR_COL);
    cmd.run_init   = (state == ST_RUN_INIT);
    cmd.run_rd     = (state == ST_RUN_RD);
    cmd.run_eval   = (state == ST_RUN_EVAL);
    cmd.run_fetch  = (state == ST_RUN_FETCH);
    cmd.rsp_load   = (state == ST_RESP) && stat.rsp_free;
  end

  // Checks
  `ECH_ASSERT_NEXT(a_take_decodes, cmd.take, state == ST_DECODE, "accepted word not decoded")
  `ECH_ASSERT_NEXT(a_fetch_evals, state == ST_RUN_FETCH, state == ST_RUN_EVAL,
                   "pop fetch not followed by evaluation")

endmodule

// ===== hw/rtl/ech_dpath.sv =====
// ----------------------------------------------------------------------------
// ech_dpath
// Datapath: adjacency rows, walk stack, path buffer and response register.
// ----------------------------------------------------------------------------
module ech_dpath
  import ech_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cmd_word_t        cmd_data,
  input  logic             vertex_count_we,
  input  logic [VTX_W-1:0] vertex_count_data,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_word_t        rsp
);

`include "euler_circuit_hierholzer_unit_defines.svh"

  cmd_word_t               cmd_q;
  logic [VTX_W-1:0]        vertex_count;
  logic [VTX_W-1:0]        n_act;
  logic                    row_ok, col_ok, start_ok, read_ok;

  logic [MAX_VERTICES-1:0] row_valid;
  logic                    row_valid_q;
  logic [ROW_AW-1:0]       row_raddr, row_waddr;
  logic [MAX_VERTICES-1:0] row_rdata, row_wdata, row_eff, row_run;
  logic                    row_we;

  logic [VTX_W-1:0]        top;
  logic [VTX_W-1:0]        pend;
  logic                    pend_valid;
  logic [SP_W-1:0]         sp, pc;
  logic [ROW_AW-1:0]       nb_idx;
  logic                    nb_found, push;
  logic [VTX_W-1:0]        nb_vtx;

  logic                    stk_we;
  logic [PATH_AW-1:0]      stk_waddr, stk_raddr;
  logic [VTX_W-1:0]        stk_wdata, stk_rdata;
  logic                    pth_we;
  logic [PATH_AW-1:0]      pth_raddr;
  logic [VTX_W-1:0]        pth_rdata;
  logic [SP_W-1:0]         sp_dec2, pth_rd_full;

  rsp_word_t               rsp_next;

  // Command word and vertex count registers
  always_ff @(posedge clk) begin
    if (cmd.take) cmd_q <= cmd_data;
  end

  always_ff @(posedge clk) begin
    if (rst)                  vertex_count <= VC_RESET;
    else if (vertex_count_we) vertex_count <= vertex_count_data;
  end

  // Active vertex count and range checks
  always_comb begin
    priority if (vertex_count == '0)                     n_act = VTX_W'(1);
    else if (vertex_count > VTX_W'(MAX_VERTICES))        n_act = VTX_W'(MAX_VERTICES);
    else                                                 n_act = vertex_count;
    row_ok   = (cmd_q.row_vertex != '0) && (cmd_q.row_vertex <= n_act);
    col_ok   = (cmd_q.col_vertex != '0) && (cmd_q.col_vertex <= n_act);
    start_ok = (cmd_q.start_vertex != '0) && (cmd_q.start_vertex <= n_act);
    read_ok  = (SP_W'(cmd_q.read_index) < pc);
  end

  // Adjacency row addressing
  always_comb begin
    if (cmd.ld_rd_row)      row_raddr = vtx_addr(cmd_q.row_vertex);
    else if (cmd.ld_rd_col) row_raddr = vtx_addr(cmd_q.col_vertex);
    else if (cmd.run_fetch) row_raddr = vtx_addr(stk_rdata);
    else                    row_raddr = vtx_addr(top);
  end

  // Row read data; a row never written since clear reads as empty
  assign row_eff  = row_valid_q ? row_rdata : '0;
  assign row_run  = row_eff & ~(pend_valid ? vtx_bit(pend) : '0);
  assign nb_found = |row_run;
  assign nb_idx   = lowest_set(row_run);
  assign nb_vtx   = {{(VTX_W-ROW_AW){1'b0}}, nb_idx} + VTX_W'(1);
  assign push     = nb_found && (sp < SP_W'(PATH_DEPTH));

  // Row write port
  always_comb begin
    row_we    = cmd.ld_wr_row || cmd.ld_wr_col || cmd.run_eval;
    row_waddr = vtx_addr(top);
    row_wdata = row_run & ~(push ? vtx_bit(nb_vtx) : '0);
    if (cmd.ld_wr_row) begin
      row_waddr = vtx_addr(cmd_q.row_vertex);
      row_wdata = row_eff | vtx_bit(cmd_q.col_vertex);
    end else if (cmd.ld_wr_col) begin
      row_waddr = vtx_addr(cmd_q.col_vertex);
      row_wdata = row_eff | vtx_bit(cmd_q.row_vertex);
    end
  end

  // Row valid bits
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_rows) row_valid <= '0;
    else if (row_we)           row_valid[row_waddr] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    row_valid_q <= row_valid[row_raddr];
  end

  ech_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_rows (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  // Walk stack ports; the entry below the top is read ahead for a pop
  assign sp_dec2   = sp - SP_W'(2);
  assign stk_we    = cmd.run_init || (cmd.run_eval && push);
  assign stk_waddr = cmd.run_init ? '0 : sp[PATH_AW-1:0];
  assign stk_wdata = cmd.run_init ? cmd_q.start_vertex : nb_vtx;
  assign stk_raddr = sp_dec2[PATH_AW-1:0];

  ech_ram #(.WIDTH(VTX_W), .DEPTH(PATH_DEPTH)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // Path buffer; reads run from the last pop backward
  assign pth_we      = cmd.run_eval && !push && (pc < SP_W'(PATH_DEPTH));
  assign pth_rd_full = pc - SP_W'(1) - SP_W'(cmd_q.read_index);
  assign pth_raddr   = pth_rd_full[PATH_AW-1:0];

  ech_ram #(.WIDTH(VTX_W), .DEPTH(PATH_DEPTH)) u_path (
    .clk   (clk),
    .we    (pth_we),
    .waddr (pc[PATH_AW-1:0]),
    .wdata (top),
    .raddr (pth_raddr),
    .rdata (pth_rdata)
  );

  // Walk control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sp         <= '0;
      pc         <= '0;
      pend_valid <= 1'b0;
    end else if (cmd.run_init) begin
      sp         <= SP_W'(1);
      pc         <= '0;
      pend_valid <= 1'b0;
    end else if (cmd.run_eval) begin
      if (push) begin
        sp         <= sp + SP_W'(1);
        pend_valid <= 1'b1;
      end else begin
        sp         <= sp - SP_W'(1);
        pend_valid <= 1'b0;
        if (pth_we) pc <= pc + SP_W'(1);
      end
    end
  end

  // Top of stack and the vertex whose edge bit is still owed to the top row
  always_ff @(posedge clk) begin
    if (cmd.run_init)                top <= cmd_q.start_vertex;
    else if (cmd.run_eval && push) begin
      top  <= nb_vtx;
      pend <= top;
    end else if (cmd.run_fetch)      top <= stk_rdata;
  end

  // Response word
  always_comb begin
    rsp_next             = '0;
    rsp_next.path_length = LEN_W'(pc);
    rsp_next.status      = STATUS_OK;
    unique case (cmd_q.action)
      ACT_CLEAR: rsp_next.status = STATUS_OK;
      ACT_LOAD:  if (!(row_ok && col_ok)) rsp_next.status = STATUS_BAD_INDEX;
      ACT_RUN:   if (!start_ok) rsp_next.status = STATUS_BAD_START;
      ACT_READ: begin
        if (read_ok) rsp_next.vertex = pth_rdata;
        else         rsp_next.status = STATUS_BAD_INDEX;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst)               rsp_valid <= 1'b0;
    else if (cmd.rsp_load) rsp_valid <= 1'b1;
    else if (!rsp_stall)   rsp_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.rsp_load) rsp <= rsp_next;
  end

  // Status to controller
  always_comb begin
    stat          = '0;
    stat.action   = cmd_q.action;
    stat.load_go  = row_ok && col_ok && cmd_q.edge_present;
    stat.start_ok = start_ok;
    stat.push     = push;
    stat.run_last = (sp == SP_W'(1));
    stat.rsp_free = !rsp_valid || !rsp_stall;
  end

  // Checks
  `ECH_ASSERT_NEXT(a_push_owes_edge, cmd.run_eval && push,
                   pend_valid && (pend == $past(top)), "pushed edge not owed to new top")
  `ECH_ASSERT_NEXT(a_pop_drops_sp, cmd.run_eval && !push,
                   sp == $past(sp) - SP_W'(1), "pop did not lower stack pointer")
  `ECH_ASSERT(a_counts_bounded, (sp <= SP_W'(PATH_DEPTH)) && (pc <= SP_W'(PATH_DEPTH)),
              "stack pointer or path count beyond depth")

endmodule

// ===== hw/rtl/euler_circuit_hierholzer_unit.sv =====
// ----------------------------------------------------------------------------
// euler_circuit_hierholzer_unit
// Euler circuit engine over an undirected adjacency-matrix graph.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd) carries one command word per
//   action: clear graph, load matrix entry, run circuit, read path entry.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns exactly one response
//   word per command. vertex_count_we / vertex_count_data write the vertex
//   count; write it only while no command is in flight.
// Sequence, from accept to response registered:
//   clear, read, rejected actions, load of an absent entry: decode, then
//   response. load: read-modify-write of both rows in the row RAM.
//   run: init, then a row read and an evaluate per edge pushed, and per
//   pop an evaluate, then stack fetch or response; the row RAM read is
//   registered and the stack RAM is read ahead for a pop.
// One command is processed at a time; the next is accepted while a response
// still waits. If the receiver stalls, the finished response holds and the
// unit waits before loading the next one.
// Reset clears the graph at once (row valid bits), the path count and the
// stack, and sets the vertex count to 64.
// ----------------------------------------------------------------------------
module euler_circuit_hierholzer_unit
  import ech_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_stall,
  input  cmd_word_t        cmd,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_word_t        rsp,
  input  logic             vertex_count_we,
  input  logic [VTX_W-1:0] vertex_count_data
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Sequencer
  ech_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  // Storage and arithmetic
  ech_dpath u_dpath (
    .clk               (clk),
    .rst               (rst),
    .cmd_data          (cmd),
    .vertex_count_we   (vertex_count_we),
    .vertex_count_data (vertex_count_data),
    .cmd               (dp_cmd),
    .stat              (dp_stat),
    .rsp_valid         (rsp_valid),
    .rsp_stall         (rsp_stall),
    .rsp               (rsp)
  );

endmodule

// ===== tb/sv/euler_circuit_hierholzer_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_circuit_hierholzer_unit_tb
// Self-checking bench for the Euler circuit engine. It loads small graphs
// entry by entry, runs the stack walk and reads the circuit back. A local
// model predicts every response word, and the bench compares each one as it
// leaves the unit, under random idle and stall bursts on both channels.
// ----------------------------------------------------------------------------
module euler_circuit_hierholzer_unit_tb;
  import ech_pkg::*;

  localparam int ITEM_TARGET    = 1050;
  localparam int CALM_AFTER     = 950;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 4;
  localparam int END_CYCLES     = 20;

  // DUT ports; inputs all driven from time zero
  logic             clk               = 1'b0;
  logic             rst               = 1'b1;
  logic             cmd_valid         = 1'b0;
  logic             cmd_stall;
  cmd_word_t        cmd               = '0;
  logic             rsp_valid;
  logic             rsp_stall         = 1'b0;
  rsp_word_t        rsp;
  logic             vertex_count_we   = 1'b0;
  logic [VTX_W-1:0] vertex_count_data = '0;

  euler_circuit_hierholzer_unit u_top (
    .clk               (clk),
    .rst               (rst),
    .cmd_valid         (cmd_valid),
    .cmd_stall         (cmd_stall),
    .cmd               (cmd),
    .rsp_valid         (rsp_valid),
    .rsp_stall         (rsp_stall),
    .rsp               (rsp),
    .vertex_count_we   (vertex_count_we),
    .vertex_count_data (vertex_count_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the graph, the walk and the vertex count register
  logic [MAX_VERTICES-1:0] adj_rows [1:MAX_VERTICES];
  logic [VTX_W-1:0]        trail_stack [PATH_DEPTH];
  logic [VTX_W-1:0]        circuit_buf [PATH_DEPTH];
  int                      circuit_len = 0;
  logic [VTX_W-1:0]        vc_reg = VC_RESET;

  rsp_word_t pending_rsp [$];

  // Bookkeeping
  int err_count      = 0;
  int n_sent         = 0;
  int n_checked      = 0;
  int n_graphs       = 0;
  int n_walks        = 0;
  int longest_walk   = 0;
  int act_seen [4]   = '{default: 0};
  int quiet_cycles   = 0;

  // Traffic shaping knobs
  int cmd_gap_pct    = 0;
  int rsp_stall_pct  = 0;
  bit calm           = 1'b0;
  int hold_req       = 0;
  int hold_left      = 0;
  int stall_left     = 0;

  // Vertex count as the unit applies it: 0 acts as 1, clipped at the top
  function automatic int usable_vertices();
    if (vc_reg < 1) return 1;
    if (vc_reg > MAX_VERTICES) return MAX_VERTICES;
    return int'(vc_reg);
  endfunction

  function automatic int lowest_neighbour(input int v);
    for (int i = 0; i < MAX_VERTICES; i++) begin
      if (adj_rows[v][i]) return i + 1;
    end
    return 0;
  endfunction

  // Hierholzer walk; the path holds vertices in pop order
  function automatic void walk_circuit(input int start);
    int depth;
    int top;
    int nb;
    depth = 0;
    circuit_len = 0;
    trail_stack[0] = VTX_W'(start);
    depth = 1;
    while (depth > 0) begin
      top = int'(trail_stack[depth-1]);
      nb  = lowest_neighbour(top);
      if (nb != 0 && depth < PATH_DEPTH) begin
        trail_stack[depth] = VTX_W'(nb);
        depth++;
        adj_rows[top][nb-1] = 1'b0;
        adj_rows[nb][top-1] = 1'b0;
      end else begin
        depth--;
        // a full path buffer drops further pops
        if (circuit_len < PATH_DEPTH) begin
          circuit_buf[circuit_len] = VTX_W'(top);
          circuit_len++;
        end
      end
    end
  endfunction

  // Applies one command word to the mirror, returns the response it gives
  function automatic rsp_word_t expected_response(input cmd_word_t w);
    rsp_word_t r;
    int        lim;
    r   = '0;
    lim = usable_vertices();
    case (w.action)
      ACT_CLEAR: begin
        for (int v = 1; v <= MAX_VERTICES; v++) adj_rows[v] = '0;
      end
      ACT_LOAD: begin
        if (w.row_vertex < 1 || w.row_vertex > lim ||
            w.col_vertex < 1 || w.col_vertex > lim) begin
          r.status = STATUS_BAD_INDEX;
        end else if (w.edge_present) begin
          adj_rows[w.row_vertex][w.col_vertex-1] = 1'b1;
          adj_rows[w.col_vertex][w.row_vertex-1] = 1'b1;
        end
      end
      ACT_RUN: begin
        if (w.start_vertex < 1 || w.start_vertex > lim) begin
          r.status = STATUS_BAD_START;
        end else begin
          walk_circuit(int'(w.start_vertex));
          n_walks++;
          if (circuit_len > longest_walk) longest_walk = circuit_len;
        end
      end
      ACT_READ: begin
        // forward order is pop order reversed
        if (int'(w.read_index) < circuit_len) begin
          r.vertex = circuit_buf[circuit_len - 1 - int'(w.read_index)];
        end else begin
          r.status = STATUS_BAD_INDEX;
        end
      end
    endcase
    r.path_length = LEN_W'(circuit_len);
    return r;
  endfunction

  // Offers one word, optionally after an idle burst, and waits for it to go
  task automatic send_cmd(input cmd_word_t w);
    int        gap;
    rsp_word_t exp_rsp;
    if (!calm && cmd_gap_pct > 0 && $urandom_range(0, 99) < cmd_gap_pct) begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      cmd_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cmd_valid <= 1'b1;
    cmd       <= w;
    do @(posedge clk); while (cmd_stall);
    exp_rsp = expected_response(w);
    pending_rsp.insert(pending_rsp.size(), exp_rsp);
    act_seen[w.action]++;
    n_sent++;
  endtask

  function automatic cmd_word_t noise_word();
    cmd_word_t w;
    w.action       = ACTION_W'($urandom);
    w.row_vertex   = VTX_W'($urandom);
    w.col_vertex   = VTX_W'($urandom);
    w.edge_present = 1'($urandom);
    w.start_vertex = VTX_W'($urandom);
    w.read_index   = IDX_W'($urandom);
    return w;
  endfunction

  task automatic do_clear();
    cmd_word_t w;
    w = noise_word();
    w.action = ACT_CLEAR;
    send_cmd(w);
  endtask

  task automatic do_load(input int row, input int col, input bit present);
    cmd_word_t w;
    w = noise_word();
    w.action       = ACT_LOAD;
    w.row_vertex   = VTX_W'(row);
    w.col_vertex   = VTX_W'(col);
    w.edge_present = present;
    send_cmd(w);
  endtask

  task automatic do_run(input int start);
    cmd_word_t w;
    w = noise_word();
    w.action       = ACT_RUN;
    w.start_vertex = VTX_W'(start);
    send_cmd(w);
  endtask

  task automatic do_read(input int idx);
    cmd_word_t w;
    w = noise_word();
    w.action     = ACT_READ;
    w.read_index = IDX_W'(idx);
    send_cmd(w);
  endtask

  // Drops valid and waits until every response is back and the unit settles
  task automatic wait_for_idle();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_vertex_count(input int v);
    wait_for_idle();
    @(negedge clk);
    vertex_count_we   <= 1'b1;
    vertex_count_data <= VTX_W'(v);
    @(negedge clk);
    vertex_count_we   <= 1'b0;
    vc_reg = VTX_W'(v);
  endtask

  // Receiver: long hold on request, else random stall bursts
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_stall <= 1'b1;
    end else if (!calm && rsp_stall_pct > 0 && $urandom_range(0, 99) < rsp_stall_pct) begin
      stall_left = $urandom_range(1, 10) - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // Response checker
  always @(posedge clk) begin : check_rsp
    rsp_word_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        $error("response word with nothing expected: %p", rsp);
        err_count++;
      end else begin
        want = pending_rsp.pop_front();
        n_checked++;
        if (rsp.vertex !== want.vertex) begin
          $error("vertex: expected %0d, got %0d", want.vertex, rsp.vertex);
          err_count++;
        end
        if (rsp.path_length !== want.path_length) begin
          $error("path_length: expected %0d, got %0d", want.path_length, rsp.path_length);
          err_count++;
        end
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          err_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles, %0d responses pending",
               quiet_cycles, pending_rsp.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Rejected starts and loads, reads of an empty path, absent entries
  task automatic test_rejects();
    do_read(0);
    do_run(0);
    do_run(MAX_VERTICES + 1);
    do_run(127);
    do_load(0, 1, 1'b1);
    do_load(1, MAX_VERTICES + 1, 1'b1);
    do_load(127, 1, 1'b1);
    do_load(2, 0, 1'b1);
    do_load(5, 6, 1'b0);
  endtask

  // Triangle with a repeated edge, a self loop, clear keeps the path
  task automatic test_triangle_walk();
    do_load(1, 2, 1'b1);
    do_load(2, 3, 1'b1);
    do_load(3, 1, 1'b1);
    do_load(2, 1, 1'b1);
    do_load(MAX_VERTICES, MAX_VERTICES, 1'b1);
    do_run(1);
    do_read(0);
    do_read(3);
    do_read(4);
    do_read(4095);
    do_run(MAX_VERTICES);
    do_read(1);
    do_clear();
    do_read(0);
    do_run(1);
    do_read(0);
  endtask

  // Receiver holds off while the sender keeps pushing words
  task automatic test_output_backpressure();
    set_vertex_count(8);
    do_clear();
    for (int v = 1; v <= 8; v++) do_load(v, (v % 8) + 1, 1'b1);
    do_load(1, 5, 1'b1);
    do_load(5, 1, 1'b1);
    hold_req = HOLD_CYCLES;
    do_run(1);
    for (int i = 0; i < 10; i++) do_read(i);
    wait_for_idle();
  endtask

  // Random graphs: clear, load, maybe shrink the count, walk, read back
  task automatic test_random_graphs();
    int extremes [6] = '{0, 1, 127, MAX_VERTICES + 1, 2, MAX_VERTICES};
    int phase;
    int lim;
    int n_loads;
    int n_reads;
    int n_noise;
    int row;
    int col;
    phase = 0;
    while (n_sent < ITEM_TARGET) begin
      cmd_gap_pct   = 15 * $urandom_range(0, 2);
      rsp_stall_pct = 15 * $urandom_range(0, 2);
      if (phase < 6) set_vertex_count(extremes[phase]);
      else if ($urandom_range(0, 9) < 7) set_vertex_count($urandom_range(2, 10));
      else if ($urandom_range(0, 1) == 0) set_vertex_count(MAX_VERTICES);
      else set_vertex_count($urandom_range(0, 127));
      lim = usable_vertices();
      n_graphs++;
      do_clear();

      n_loads = $urandom_range(1, (3 * lim > 40) ? 40 : 3 * lim);
      for (int i = 0; i < n_loads; i++) begin
        if ($urandom_range(0, 99) < 85) begin
          row = $urandom_range(1, lim);
          col = $urandom_range(1, lim);
        end else begin
          row = $urandom_range(0, 127);
          col = $urandom_range(0, 127);
        end
        do_load(row, col, $urandom_range(0, 99) < 85);
      end

      // stray words of any kind
      n_noise = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      for (int i = 0; i < n_noise; i++) send_cmd(noise_word());

      // count lowered after loading: old edges still count
      if ($urandom_range(0, 4) == 0) begin
        set_vertex_count($urandom_range(0, lim));
        lim = usable_vertices();
      end

      do_run(($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, lim));
      n_reads = $urandom_range(2, 8);
      for (int i = 0; i < n_reads; i++) begin
        if ($urandom_range(0, 4) == 0) do_read($urandom_range(0, 4095));
        else do_read($urandom_range(0, circuit_len));
      end

      // a second walk from a random start finds the edges consumed
      if ($urandom_range(0, 5) == 0) begin
        do_run($urandom_range(1, lim));
        do_read(0);
      end

      if (n_sent >= CALM_AFTER) calm = 1'b1;
      phase++;
    end
    wait_for_idle();
  endtask

  initial begin
    for (int v = 1; v <= MAX_VERTICES; v++) adj_rows[v] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_rejects();
    test_triangle_walk();
    test_output_backpressure();
    test_random_graphs();

    repeat (END_CYCLES) @(posedge clk);
    if (pending_rsp.size() != 0) begin
      $error("%0d expected responses never arrived", pending_rsp.size());
      err_count++;
    end
    $display("Sent %0d words over %0d graphs: %0d clears, %0d loads, %0d runs, %0d reads",
             n_sent, n_graphs, act_seen[ACT_CLEAR], act_seen[ACT_LOAD],
             act_seen[ACT_RUN], act_seen[ACT_READ]);
    $display("Checked %0d responses, %0d walks done, longest circuit %0d vertices",
             n_checked, n_walks, longest_walk);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== euler_circuit_hierholzer_unit.f =====
+incdir+hw/rtl
hw/rtl/ech_pkg.sv
hw/rtl/ech_ram.sv
hw/rtl/ech_ctrl.sv
hw/rtl/ech_dpath.sv
hw/rtl/euler_circuit_hierholzer_unit.sv
tb/sv/euler_circuit_hierholzer_unit_tb.sv
